/* rtl/orientation_vectors_to_quaternion_macros.svh */
// ----------------------------------------------------------------------------
// Orientation vectors to quaternion: assertion macros
// Concurrent check wrappers, empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ORIENTATION_VECTORS_TO_QUATERNION_MACROS_SVH
`define ORIENTATION_VECTORS_TO_QUATERNION_MACROS_SVH
`ifndef SYNTHESIS
`define OVQ_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`define OVQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define OVQ_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`define OVQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/ovq_pkg.sv */
// ----------------------------------------------------------------------------
// Orientation vectors to quaternion: package
// Payload types, selection codes and width helpers.
// ----------------------------------------------------------------------------
package ovq_pkg;

	localparam int DATA_W = 16;
	localparam int FRAC_BITS_DEF = 14;

	typedef struct packed {
		logic signed [DATA_W-1:0] up_x;
		logic signed [DATA_W-1:0] up_y;
		logic signed [DATA_W-1:0] up_z;
		logic signed [DATA_W-1:0] dir_x;
		logic signed [DATA_W-1:0] dir_y;
		logic signed [DATA_W-1:0] dir_z;
	} ovq_in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] quat_w;
		logic signed [DATA_W-1:0] quat_x;
		logic signed [DATA_W-1:0] quat_y;
		logic signed [DATA_W-1:0] quat_z;
	} ovq_out_t;

	localparam logic [1:0] POS_W = 2'd0;
	localparam logic [1:0] POS_X = 2'd1;
	localparam logic [1:0] POS_Y = 2'd2;
	localparam logic [1:0] POS_Z = 2'd3;

	// cross product element width
	function automatic int cross_w(int fb);
		return (2 * DATA_W + 1 - fb > DATA_W) ? 2 * DATA_W + 1 - fb : DATA_W;
	endfunction

	// signed root argument width
	function automatic int arg_w(int fb);
		return ((cross_w(fb) > fb + 1) ? cross_w(fb) : fb + 1) + 3;
	endfunction

	function automatic int num_w(int fb);
		return cross_w(fb) + 1;
	endfunction

	function automatic int item_w(int fb);
		return 2 + arg_w(fb) - 1 + 3 * num_w(fb);
	endfunction

endpackage

/* rtl/orientation_vectors_to_quaternion.sv */
// ----------------------------------------------------------------------------
// Orientation vectors to quaternion
// Up vector and x-direction vector in, unit quaternion out, all Q2.14.
// ----------------------------------------------------------------------------
// Usage:
//   Drive operand and raise start; the item is taken at a clock edge with
//   start high and busy low. One result per item appears on result with
//   done high for exactly one cycle; it must be captured then.
//   A new item may be taken every cycle. RW = (arg width + FRAC_BITS + 1) / 2
//   is the number of square root stages. An item passes two front stages,
//   the queue, one root bit per stage, divider setup, one quotient bit per
//   divider stage, and the output register.
//   The square root and divider pipelines set the latency; each takes an
//   item every cycle, so throughput is one item per cycle.
//   Results leave in the order items were taken. The back end never
//   stalls, so busy stays low in normal use.
//   Reset clears all valid flags; items in flight are dropped and no done
//   strobe follows until a new item is taken.
// ----------------------------------------------------------------------------
module orientation_vectors_to_quaternion #(
	parameter int FRAC_BITS = ovq_pkg::FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ovq_pkg::ovq_in_t  operand,
	output logic              done,
	output ovq_pkg::ovq_out_t result
);
	import ovq_pkg::*;

	localparam int IW = item_w(FRAC_BITS);

	logic fr_valid, bk_valid;
	logic [IW-1:0] fr_data, bk_data;

	ovq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (start && !busy),
		.in_data    (operand),
		.item_valid (fr_valid),
		.item_data  (fr_data)
	);

	ovq_queue #(.W(IW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fr_valid),
		.push_data (fr_data),
		.full      (busy),
		.out_valid (bk_valid),
		.out_data  (bk_data)
	);

	ovq_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (bk_valid),
		.item_data  (bk_data),
		.done       (done),
		.result     (result)
	);

endmodule

/* rtl/ovq_front.sv */
// ----------------------------------------------------------------------------
// Orientation vectors to quaternion: front end
// Builds the matrix, picks the conversion branch, forms root argument and
// numerators.
// ----------------------------------------------------------------------------
module ovq_front #(
	parameter int FRAC_BITS = ovq_pkg::FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	input  ovq_pkg::ovq_in_t                       in_data,
	output logic                                   item_valid,
	output logic [ovq_pkg::item_w(FRAC_BITS)-1:0]  item_data
);
	import ovq_pkg::*;

	localparam int DW = DATA_W;
	localparam int XW = cross_w(FRAC_BITS);
	localparam int AW = arg_w(FRAC_BITS);
	localparam int AUW = AW - 1;
	localparam int NW = num_w(FRAC_BITS);
	localparam int PW = 2 * DW + 1;
	localparam logic signed [AW-1:0] ONE = AW'(1) << FRAC_BITS;

	logic signed [2*DW-1:0] p_s1 [6];
	logic signed [DW-1:0] ux_s1, uy_s1, uz_s1, dx_s1, dy_s1, dz_s1;
	logic v_s1, v_s2;
	logic [item_w(FRAC_BITS)-1:0] item_s2;

	logic signed [PW-1:0] d0, d1, d2;
	logic signed [XW-1:0] c0, c1, c2;
	logic signed [AW-1:0] tr, arg_t, arg0, arg1, arg2, arg_sel;
	logic signed [NW-1:0] na, nb, nc, s01, s02, s12, n0, n1, n2;
	logic [1:0] pos;
	logic [AUW-1:0] arg_c;

	always_comb begin
		d0 = PW'(p_s1[0]) - PW'(p_s1[1]);
		d1 = PW'(p_s1[2]) - PW'(p_s1[3]);
		d2 = PW'(p_s1[4]) - PW'(p_s1[5]);
		c0 = XW'(d0 >>> FRAC_BITS);
		c1 = XW'(d1 >>> FRAC_BITS);
		c2 = XW'(d2 >>> FRAC_BITS);
		tr = AW'(dx_s1) + AW'(uy_s1) + AW'(c2);
		arg_t = tr + ONE;
		arg0 = ONE + AW'(dx_s1) - AW'(uy_s1) - AW'(c2);
		arg1 = ONE + AW'(uy_s1) - AW'(dx_s1) - AW'(c2);
		arg2 = ONE + AW'(c2) - AW'(dx_s1) - AW'(uy_s1);
		na = NW'(uz_s1) - NW'(c1);
		nb = NW'(c0) - NW'(dz_s1);
		nc = NW'(dy_s1) - NW'(ux_s1);
		s01 = NW'(ux_s1) + NW'(dy_s1);
		s02 = NW'(c0) + NW'(dz_s1);
		s12 = NW'(c1) + NW'(uz_s1);
		if (tr > 0) begin
			pos = POS_W; arg_sel = arg_t; n0 = na; n1 = nb; n2 = nc;
		end else if (XW'(dx_s1) > XW'(uy_s1) && XW'(dx_s1) > c2) begin
			pos = POS_X; arg_sel = arg0; n0 = na; n1 = s01; n2 = s02;
		end else if (XW'(uy_s1) > c2) begin
			pos = POS_Y; arg_sel = arg1; n0 = nb; n1 = s01; n2 = s12;
		end else begin
			pos = POS_Z; arg_sel = arg2; n0 = nc; n1 = s02; n2 = s12;
		end
		arg_c = arg_sel[AW-1] ? '0 : arg_sel[AUW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		p_s1[0] <= in_data.dir_y * in_data.up_z;
		p_s1[1] <= in_data.dir_z * in_data.up_y;
		p_s1[2] <= in_data.dir_z * in_data.up_x;
		p_s1[3] <= in_data.dir_x * in_data.up_z;
		p_s1[4] <= in_data.dir_x * in_data.up_y;
		p_s1[5] <= in_data.dir_y * in_data.up_x;
		ux_s1 <= in_data.up_x;
		uy_s1 <= in_data.up_y;
		uz_s1 <= in_data.up_z;
		dx_s1 <= in_data.dir_x;
		dy_s1 <= in_data.dir_y;
		dz_s1 <= in_data.dir_z;
		item_s2 <= {pos, arg_c, n0, n1, n2};
	end

	assign item_valid = v_s2;
	assign item_data = item_s2;

endmodule

/* rtl/ovq_queue.sv */
// ----------------------------------------------------------------------------
// Orientation vectors to quaternion: decoupling queue
// Two-entry queue between front end and back end, registered read.
// ----------------------------------------------------------------------------
`include "orientation_vectors_to_quaternion_macros.svh"
module ovq_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	output logic         out_valid,
	output logic [W-1:0] out_data
);
	localparam int DEPTH = 2;
	localparam int PTRW = $clog2(DEPTH);
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [W-1:0] mem [DEPTH];
	logic [PTRW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0] count_q;
	logic out_valid_q;
	logic [W-1:0] out_data_q;
	logic pop, wr_en;

	assign pop = (count_q != '0);
	assign full = (count_q == CNTW'(DEPTH));
	assign wr_en = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (wr_en && !pop) count_q <= count_q + 1'b1;
			else if (!wr_en && pop) count_q <= count_q - 1'b1;
			out_valid_q <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_ptr_q] <= push_data;
		out_data_q <= mem[rd_ptr_q];
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	`OVQ_ASSERT_NEVER(a_no_overflow, clk, arst_n, push && full, "queue overflow")
	`OVQ_ASSERT_NEXT(a_fill_one, clk, arst_n, push && (count_q == '0), count_q == CNTW'(1), "queue count")
	`OVQ_ASSERT_NEXT(a_drain, clk, arst_n, count_q != '0, out_valid_q, "queue did not drain")

endmodule

/* rtl/ovq_back.sv */
// ----------------------------------------------------------------------------
// Orientation vectors to quaternion: back end
// Pipelined square root, three pipelined dividers, saturation and placement.
// ----------------------------------------------------------------------------
module ovq_back #(
	parameter int FRAC_BITS = ovq_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  item_valid,
	input  logic [ovq_pkg::item_w(FRAC_BITS)-1:0] item_data,
	output logic                                  done,
	output ovq_pkg::ovq_out_t                     result
);
	import ovq_pkg::*;

	localparam int DW = DATA_W;
	localparam int AUW = arg_w(FRAC_BITS) - 1;
	localparam int NUMW = num_w(FRAC_BITS);
	localparam int RW = (AUW + FRAC_BITS + 1) / 2;
	localparam int SQW = 2 * RW;
	localparam int TW = SQW + 1;
	localparam int DNW = RW + 1;
	localparam int NNW = NUMW + FRAC_BITS;
	localparam int CW = ((NNW > DNW + DW) ? NNW : DNW + DW) + 1;
	localparam int MW = (RW > DW) ? RW : DW;
	localparam logic signed [DW-1:0] OUT_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] OUT_MIN = {1'b1, {(DW-1){1'b0}}};

	logic [1:0] in_pos;
	logic [AUW-1:0] in_arg;
	logic signed [NUMW-1:0] in_num [3];
	assign {in_pos, in_arg, in_num[0], in_num[1], in_num[2]} = item_data;

	logic sq_v_s [RW+1];
	logic [SQW-1:0] sq_rem_s [RW+1];
	logic [RW-1:0] sq_root_s [RW+1];
	logic [1:0] sq_pos_s [RW+1];
	logic signed [NUMW-1:0] sq_num_s [RW+1][3];

	assign sq_v_s[0] = item_valid;
	assign sq_rem_s[0] = SQW'({in_arg, {FRAC_BITS{1'b0}}});
	assign sq_root_s[0] = '0;
	assign sq_pos_s[0] = in_pos;
	assign sq_num_s[0] = in_num;

	for (genvar j = 0; j < RW; j++) begin : g_sq
		localparam int K = RW - 1 - j;
		logic [TW-1:0] trial;
		logic hit;
		assign trial = (TW'(sq_root_s[j]) << (K + 1)) | (TW'(1) << (2 * K));
		assign hit = TW'(sq_rem_s[j]) >= trial;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_v_s[j+1] <= 1'b0;
			else sq_v_s[j+1] <= sq_v_s[j];
		end
		always_ff @(posedge clk) begin
			sq_rem_s[j+1] <= hit ? SQW'(TW'(sq_rem_s[j]) - trial) : sq_rem_s[j];
			sq_root_s[j+1] <= hit ? (sq_root_s[j] | (RW'(1) << K)) : sq_root_s[j];
			sq_pos_s[j+1] <= sq_pos_s[j];
			sq_num_s[j+1] <= sq_num_s[j];
		end
	end

	logic dv_v_s [DW+1];
	logic [1:0] dv_pos_s [DW+1];
	logic [DNW-1:0] dv_den_s [DW+1];
	logic signed [DW-1:0] dv_dir_s [DW+1];
	logic [CW-1:0] dv_rem_s [DW+1][3];
	logic [DW-1:0] dv_q_s [DW+1][3];
	logic dv_sgn_s [DW+1][3];
	logic dv_zero_s [DW+1][3];
	logic dv_ovf_s [DW+1][3];

	logic [DNW-1:0] den;
	logic [MW-1:0] half_root;
	logic signed [DW-1:0] dir_sat;
	logic [NUMW-1:0] mag [3];
	logic [NNW-1:0] nn [3];

	always_comb begin
		den = {sq_root_s[RW], 1'b0};
		half_root = MW'(sq_root_s[RW] >> 1);
		dir_sat = (half_root > MW'(OUT_MAX)) ? OUT_MAX : DW'(half_root);
		for (int i = 0; i < 3; i++) begin
			mag[i] = sq_num_s[RW][i][NUMW-1] ? NUMW'(-sq_num_s[RW][i]) : NUMW'(sq_num_s[RW][i]);
			nn[i] = {mag[i], {FRAC_BITS{1'b0}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_v_s[0] <= 1'b0;
		else dv_v_s[0] <= sq_v_s[RW];
	end

	always_ff @(posedge clk) begin
		dv_pos_s[0] <= sq_pos_s[RW];
		dv_den_s[0] <= den;
		dv_dir_s[0] <= dir_sat;
		for (int i = 0; i < 3; i++) begin
			dv_rem_s[0][i] <= CW'(nn[i]);
			dv_q_s[0][i] <= '0;
			dv_sgn_s[0][i] <= sq_num_s[RW][i][NUMW-1];
			dv_zero_s[0][i] <= (mag[i] == '0);
			dv_ovf_s[0][i] <= CW'(nn[i] >> DW) >= CW'(den);
		end
	end

	for (genvar j = 0; j < DW; j++) begin : g_dv
		localparam int K = DW - 1 - j;
		logic [CW-1:0] sub;
		assign sub = CW'(dv_den_s[j]) << K;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v_s[j+1] <= 1'b0;
			else dv_v_s[j+1] <= dv_v_s[j];
		end
		always_ff @(posedge clk) begin
			dv_pos_s[j+1] <= dv_pos_s[j];
			dv_den_s[j+1] <= dv_den_s[j];
			dv_dir_s[j+1] <= dv_dir_s[j];
			dv_sgn_s[j+1] <= dv_sgn_s[j];
			dv_zero_s[j+1] <= dv_zero_s[j];
			dv_ovf_s[j+1] <= dv_ovf_s[j];
			for (int i = 0; i < 3; i++) begin
				if (dv_rem_s[j][i] >= sub) begin
					dv_rem_s[j+1][i] <= dv_rem_s[j][i] - sub;
					dv_q_s[j+1][i] <= dv_q_s[j][i] | (DW'(1) << K);
				end else begin
					dv_rem_s[j+1][i] <= dv_rem_s[j][i];
					dv_q_s[j+1][i] <= dv_q_s[j][i];
				end
			end
		end
	end

	logic signed [DW-1:0] qv [3];
	ovq_out_t res_d;
	ovq_out_t result_q;
	logic done_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (dv_zero_s[DW][i]) qv[i] = '0;
			else if (dv_ovf_s[DW][i]) qv[i] = dv_sgn_s[DW][i] ? OUT_MIN : OUT_MAX;
			else if (dv_sgn_s[DW][i])
				qv[i] = (dv_q_s[DW][i] > DW'(OUT_MIN)) ? OUT_MIN : -$signed(dv_q_s[DW][i]);
			else
				qv[i] = (dv_q_s[DW][i] > DW'(OUT_MAX)) ? OUT_MAX : $signed(dv_q_s[DW][i]);
		end
		case (dv_pos_s[DW])
			POS_W: res_d = '{quat_w: dv_dir_s[DW], quat_x: qv[0], quat_y: qv[1], quat_z: qv[2]};
			POS_X: res_d = '{quat_w: qv[0], quat_x: dv_dir_s[DW], quat_y: qv[1], quat_z: qv[2]};
			POS_Y: res_d = '{quat_w: qv[0], quat_x: qv[1], quat_y: dv_dir_s[DW], quat_z: qv[2]};
			default: res_d = '{quat_w: qv[0], quat_x: qv[1], quat_y: qv[2], quat_z: dv_dir_s[DW]};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= dv_v_s[DW];
	end

	always_ff @(posedge clk) begin
		result_q <= res_d;
	end

	assign done = done_q;
	assign result = result_q;

endmodule

/* bench/tb_orientation_vectors_to_quaternion.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Orientation vectors to quaternion: testbench
// Drives pose samples through the command handshake with random sender
// gaps, predicts each quaternion in fixed point and checks results in order.
// ----------------------------------------------------------------------------
module tb_orientation_vectors_to_quaternion;
	import ovq_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam longint ONE = longint'(1) << FB;
	localparam longint CAP = (longint'(1) << (62 - FB)) - 1;
	localparam longint OMAX = (longint'(1) << (DATA_W - 1)) - 1;
	localparam longint OMIN = -(longint'(1) << (DATA_W - 1));
	localparam longint CYCLE_LIMIT = 400000;

	function automatic longint sat16(longint v);
		return (v > OMAX) ? OMAX : (v < OMIN) ? OMIN : v;
	endfunction

	function automatic longint cap_arg(longint v);
		return (v > CAP) ? CAP : (v < -CAP) ? -CAP : v;
	endfunction

	function automatic longint fx_sqrt(longint a);
		longint unsigned v, res, b;
		if (a < 0)
			a = 0;
		v = longint'(cap_arg(a)) << FB;
		res = 0;
		b = longint'(1) << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic longint fx_quot(longint num, longint den);
		num = cap_arg(num);
		if (den <= 0)
			return (num > 0) ? OMAX : (num < 0) ? OMIN : 0;
		return sat16((num * ONE) / den);
	endfunction

	function automatic ovq_out_t pose_to_quat(ovq_in_t p);
		longint m[3][3];
		longint tr, r, s, w, x, y, z;
		ovq_out_t q;
		m[0][0] = p.dir_x; m[0][1] = p.up_x;
		m[1][0] = p.dir_y; m[1][1] = p.up_y;
		m[2][0] = p.dir_z; m[2][1] = p.up_z;
		m[0][2] = (longint'(p.dir_y) * p.up_z - longint'(p.dir_z) * p.up_y) >>> FB;
		m[1][2] = (longint'(p.dir_z) * p.up_x - longint'(p.dir_x) * p.up_z) >>> FB;
		m[2][2] = (longint'(p.dir_x) * p.up_y - longint'(p.dir_y) * p.up_x) >>> FB;
		tr = m[0][0] + m[1][1] + m[2][2];
		if (tr > 0) begin
			r = fx_sqrt(tr + ONE);
			w = sat16(r >>> 1);
			x = fx_quot(m[2][1] - m[1][2], 2 * r);
			y = fx_quot(m[0][2] - m[2][0], 2 * r);
			z = fx_quot(m[1][0] - m[0][1], 2 * r);
		end else if (m[0][0] > m[1][1] && m[0][0] > m[2][2]) begin
			s = 2 * fx_sqrt(ONE + m[0][0] - m[1][1] - m[2][2]);
			w = fx_quot(m[2][1] - m[1][2], s);
			x = sat16(s >>> 2);
			y = fx_quot(m[0][1] + m[1][0], s);
			z = fx_quot(m[0][2] + m[2][0], s);
		end else if (m[1][1] > m[2][2]) begin
			s = 2 * fx_sqrt(ONE + m[1][1] - m[0][0] - m[2][2]);
			w = fx_quot(m[0][2] - m[2][0], s);
			x = fx_quot(m[0][1] + m[1][0], s);
			y = sat16(s >>> 2);
			z = fx_quot(m[1][2] + m[2][1], s);
		end else begin
			s = 2 * fx_sqrt(ONE + m[2][2] - m[0][0] - m[1][1]);
			w = fx_quot(m[1][0] - m[0][1], s);
			x = fx_quot(m[0][2] + m[2][0], s);
			y = fx_quot(m[1][2] + m[2][1], s);
			z = sat16(s >>> 2);
		end
		q.quat_w = w[DATA_W-1:0];
		q.quat_x = x[DATA_W-1:0];
		q.quat_y = y[DATA_W-1:0];
		q.quat_z = z[DATA_W-1:0];
		return q;
	endfunction

	class quat_scoreboard;
		ovq_out_t pending[$];
		int errors;

		function void note_pose(ovq_in_t p);
			pending.insert(pending.size(), pose_to_quat(p));
		endfunction

		function void check_quat(ovq_out_t got);
			ovq_out_t want;
			if (pending.size() == 0) begin
				$error("unexpected result %h", got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.quat_w !== want.quat_w) begin
				$error("quat_w exp %0d got %0d", want.quat_w, got.quat_w); errors++;
			end
			if (got.quat_x !== want.quat_x) begin
				$error("quat_x exp %0d got %0d", want.quat_x, got.quat_x); errors++;
			end
			if (got.quat_y !== want.quat_y) begin
				$error("quat_y exp %0d got %0d", want.quat_y, got.quat_y); errors++;
			end
			if (got.quat_z !== want.quat_z) begin
				$error("quat_z exp %0d got %0d", want.quat_z, got.quat_z); errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	ovq_in_t operand;
	ovq_out_t result;
	quat_scoreboard sb;
	longint cycles;
	int gap_pct;

	orientation_vectors_to_quaternion dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operand(operand),
		.done(done),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && done)
			sb.check_quat(result);
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_orientation_vectors_to_quaternion: done, errors");
			$finish;
		end
	end

	function automatic logic [DATA_W-1:0] pick_comp();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return ($urandom_range(0, 1)) ? 16'h4000 : 16'hc000;
			default: return DATA_W'($urandom());
		endcase
	endfunction

	// raw words, corner components, or components within about plus or minus one
	function automatic ovq_in_t pick_pose();
		ovq_in_t p;
		int k;
		k = $urandom_range(0, 9);
		if (k < 4) begin
			p = {$urandom(), $urandom(), $urandom()};
		end else if (k < 6) begin
			p.up_x = pick_comp(); p.up_y = pick_comp(); p.up_z = pick_comp();
			p.dir_x = pick_comp(); p.dir_y = pick_comp(); p.dir_z = pick_comp();
		end else begin
			p = '0;
			p.dir_x = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
			p.dir_y = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
			p.dir_z = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
			p.up_x = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
			p.up_y = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
			p.up_z = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
		end
		return p;
	endfunction

	task automatic send_pose(ovq_in_t p);
		while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		operand <= p;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_pose(p);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		ovq_in_t p;
		ovq_in_t d[$];
		sb = new();
		cycles = 0;
		gap_pct = 0;
		arst_n = 1'b0;
		start = 1'b0;
		operand = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity, axis swaps for each branch, zeros and extremes
		d.insert(d.size(), {16'sd0, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 16'sd0});
		d.insert(d.size(), {16'sd0, -16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 16'sd0});
		d.insert(d.size(), {16'sd0, 16'sd16384, 16'sd0, -16'sd16384, 16'sd0, 16'sd0});
		d.insert(d.size(), {16'sd0, -16'sd16384, 16'sd0, -16'sd16384, 16'sd0, 16'sd0});
		d.insert(d.size(), {16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0});
		d.insert(d.size(), {16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384});
		d.insert(d.size(), {16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd16384, 16'sd0});
		d.insert(d.size(), '0);
		d.insert(d.size(), {6{16'h8000}});
		d.insert(d.size(), {6{16'h7fff}});
		d.insert(d.size(), {16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
		d.insert(d.size(), {16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
		d.insert(d.size(), {16'sd0, 16'sd0, 16'sd0, -16'sd16384, -16'sd16384, -16'sd16384});
		d.insert(d.size(), {16'h7fff, 16'sd0, 16'sd0, 16'h8000, 16'sd0, 16'sd0});
		d.insert(d.size(), {16'sd0, 16'h8000, 16'sd0, 16'sd0, 16'sd0, 16'h7fff});
		d.insert(d.size(), {16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1});
		d.insert(d.size(), {16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0});
		foreach (d[i])
			send_pose(d[i]);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			gap_pct = (ph == 1) ? 47 : (ph == 2) ? 23 : 0;
			for (int n = 0; n < 470; n++) begin
				p = pick_pose();
				send_pose(p);
			end
			drain();
		end

		repeat (60) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb_orientation_vectors_to_quaternion: done, clean");
		else
			$display("tb_orientation_vectors_to_quaternion: done, errors");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl
rtl/ovq_pkg.sv
rtl/ovq_front.sv
rtl/ovq_queue.sv
rtl/ovq_back.sv
rtl/orientation_vectors_to_quaternion.sv
bench/tb_orientation_vectors_to_quaternion.sv
